[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/clt_pkg.sv]
// Shared types, constants and character-class functions of the command line tokenizer.
// No dependencies; every module of the block imports this package.
package clt_pkg;

    localparam int POS_W    = 13;
    localparam int LINE_MAX = 4096;
    localparam logic [POS_W-1:0] LINE_MAX_POS = POS_W'(LINE_MAX);

    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [2:0] TOK_END    = 3'd0;
    localparam logic [2:0] TOK_EQUALS = 3'd1;
    localparam logic [2:0] TOK_QUOTED = 3'd2;
    localparam logic [2:0] TOK_LONG   = 3'd3;
    localparam logic [2:0] TOK_SHORT  = 3'd4;
    localparam logic [2:0] TOK_IDENT  = 3'd5;
    localparam logic [2:0] TOK_VALUE  = 3'd6;
    localparam logic [2:0] TOK_UNTERM = 3'd7;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_DASH  = 3'd2,
        MODE_LONG  = 3'd3,
        MODE_SHORT = 3'd4,
        MODE_QUOTE = 3'd5,
        MODE_QESC  = 3'd6
    } t_mode;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_in;
    } t_item;

    typedef struct packed {
        logic [2:0]       token_type;
        logic [POS_W-1:0] token_pos;
        logic [POS_W-1:0] text_start;
        logic [POS_W-1:0] text_length;
        logic             last_of_run;
        logic             overflow;
    } t_result;

    // Results of one scanned item, first in delivery order.
    typedef struct packed {
        t_result    first;
        t_result    second;
        logic [1:0] count;
    } t_scan_res;

    function automatic logic is_alnum(input logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDERSCORE};
    endfunction

    // Bytes that end a word.
    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Bytes that are skipped between tokens.
    function automatic logic is_blank(input logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    endfunction

    function automatic logic [POS_W-1:0] len_from(input logic [POS_W-1:0] from,
                                                  input logic [POS_W-1:0] upto);
        return (upto >= from) ? (upto - from) : '0;
    endfunction

endpackage

[rtl/core/command_line_tokenizer.sv]
// Command line tokenizer: bytes of a line in, token descriptors out.
// Depends on clt_pkg, clt_scan and clt_outbuf.
//
// Input channel (i_in_valid, i_in_item, o_in_stall): one item is a data byte, or an
// end command that closes the line. Output channel (o_out_valid, o_out_item,
// i_out_stall): one token descriptor per item moved; last_of_run marks the last
// descriptor caused by one input item.
// An accepted item sits in the input register and is scanned there; its first
// descriptor is written to the result register when the item is taken, and shows
// on the output from there.
// Throughput: one input item per cycle while the receiver keeps up. An item that
// yields two descriptors (a token closed by '=' or by the end command) parks its
// second one in the pending slot of the single result register, and the next item
// waits until that slot drains.
// While the receiver stalls, the waiting descriptor holds and one more input item
// is still taken into the input register; items with no descriptor keep flowing.
// Reset clears the scan state (between tokens, position zero, no overflow) and
// empties input, result and pending slots; the end command clears the scan state alike.
module command_line_tokenizer import clt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_item   i_in_item,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_out_item,
    input  logic    i_out_stall
);

    logic      r_in_v, n_in_v;
    t_item     r_in;
    logic      fire;
    logic      in_accept;
    t_scan_res scan_res;

    always_comb begin
        o_in_stall = r_in_v && !fire;
        in_accept  = i_in_valid && !o_in_stall;
        n_in_v     = in_accept || (r_in_v && !fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= n_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    clt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (scan_res)
    );

    clt_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (r_in_v),
        .i_res       (scan_res),
        .o_take      (fire),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

[rtl/core/clt_scan.sv]
// Scan state of the tokenizer and the per-item logic that updates it and forms results.
// Depends on clt_pkg.
module clt_scan import clt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_item     i_item,
    output t_scan_res o_res
);

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_origin, n_origin;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_alnum, n_alnum;
    logic             r_ovf, n_ovf;

    logic [7:0]       b;
    logic             at_max;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] qs;
    logic             has_open;
    logic             do_close;
    logic             terminated;
    logic             reidle;
    logic             emit_eq;
    logic             flag_ovf;
    t_result          tok_close;
    t_result          tok_eq;
    t_result          tok_end;

    always_comb begin
        b      = i_item.byte_in;
        at_max = (r_pos >= LINE_MAX_POS);
        p      = at_max ? LINE_MAX_POS : r_pos;
        qs     = (r_origin >= LINE_MAX_POS) ? LINE_MAX_POS : r_origin + POS_W'(1);

        n_mode     = r_mode;
        n_origin   = r_origin;
        n_alnum    = r_alnum;
        n_ovf      = r_ovf | at_max;
        n_pos      = at_max ? p : p + POS_W'(1);
        do_close   = 1'b0;
        terminated = 1'b0;
        reidle     = 1'b0;
        emit_eq    = 1'b0;

        case (r_mode)
            MODE_WORD, MODE_DASH, MODE_LONG, MODE_SHORT, MODE_QUOTE, MODE_QESC: begin
                has_open = 1'b1;
            end
            default: begin
                has_open = 1'b0;
            end
        endcase

        case (r_mode)
            MODE_WORD: begin
                if (is_space(b) || b == CH_EQUALS) begin
                    do_close = 1'b1;
                    reidle   = 1'b1;
                end else if (!is_alnum(b)) begin
                    n_alnum = 1'b0;
                end
            end
            MODE_DASH: begin
                if (b == CH_DASH) begin
                    n_mode = MODE_LONG;
                end else if (!is_alnum(b)) begin
                    do_close = 1'b1;
                    reidle   = 1'b1;
                end else begin
                    n_mode = MODE_SHORT;
                end
            end
            MODE_LONG, MODE_SHORT: begin
                if (!is_alnum(b)) begin
                    do_close = 1'b1;
                    reidle   = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (b == CH_QUOTE) begin
                    do_close   = 1'b1;
                    terminated = 1'b1;
                    n_mode     = MODE_IDLE;
                end else if (b == CH_BACKSLASH) begin
                    n_mode = MODE_QESC;
                end
            end
            MODE_QESC: begin
                // An escaped quote stays in the value; a second backslash escapes again.
                n_mode = (b == CH_BACKSLASH) ? MODE_QESC : MODE_QUOTE;
            end
            default: begin
                reidle = 1'b1;
            end
        endcase

        // A byte that closed a word or flag is scanned again as if between tokens, like any idle byte.
        if (reidle) begin
            n_mode = MODE_IDLE;
            if (is_blank(b)) begin
                n_mode = MODE_IDLE;
            end else if (b == CH_EQUALS) begin
                emit_eq = 1'b1;
            end else begin
                n_origin = p;
                if (b == CH_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else if (b == CH_DASH) begin
                    n_mode = MODE_DASH;
                end else begin
                    n_mode  = MODE_WORD;
                    n_alnum = is_alnum(b);
                end
            end
        end

        flag_ovf = (i_item.command == CMD_END) ? r_ovf : n_ovf;

        tok_close.token_pos   = r_origin;
        tok_close.text_start  = r_origin;
        tok_close.last_of_run = 1'b0;
        tok_close.overflow    = flag_ovf;
        case (r_mode)
            MODE_WORD: begin
                tok_close.token_type = r_alnum ? TOK_IDENT : TOK_VALUE;
            end
            MODE_DASH, MODE_SHORT: begin
                tok_close.token_type = TOK_SHORT;
            end
            MODE_LONG: begin
                tok_close.token_type = TOK_LONG;
            end
            MODE_QUOTE, MODE_QESC: begin
                // The byte field of an end command is not a closing quote.
                tok_close.token_type = (terminated && i_item.command == CMD_DATA) ?
                                       TOK_QUOTED : TOK_UNTERM;
                tok_close.text_start = qs;
            end
            default: begin
                tok_close.token_type = TOK_END;
            end
        endcase
        tok_close.text_length = len_from(tok_close.text_start, p);

        tok_eq.token_type  = TOK_EQUALS;
        tok_eq.token_pos   = p;
        tok_eq.text_start  = p;
        tok_eq.text_length = POS_W'(1);
        tok_eq.last_of_run = 1'b1;
        tok_eq.overflow    = flag_ovf;

        tok_end.token_type  = TOK_END;
        tok_end.token_pos   = r_pos;
        tok_end.text_start  = r_pos;
        tok_end.text_length = '0;
        tok_end.last_of_run = 1'b1;
        tok_end.overflow    = flag_ovf;

        if (i_item.command == CMD_END) begin
            o_res.first  = has_open ? tok_close : tok_end;
            o_res.second = tok_end;
            o_res.count  = has_open ? 2'd2 : 2'd1;
            n_mode       = MODE_IDLE;
            n_origin     = '0;
            n_pos        = '0;
            n_alnum      = 1'b1;
            n_ovf        = 1'b0;
        end else begin
            o_res.first  = do_close ? tok_close : tok_eq;
            o_res.second = tok_eq;
            o_res.count  = {1'b0, do_close} + {1'b0, emit_eq};
        end
        o_res.first.last_of_run = (o_res.count == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_origin <= '0;
            r_pos    <= '0;
            r_alnum  <= 1'b1;
            r_ovf    <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_origin <= n_origin;
            r_pos    <= n_pos;
            r_alnum  <= n_alnum;
            r_ovf    <= n_ovf;
        end
    end

endmodule

[rtl/core/clt_outbuf.sv]
// Result register with one pending slot for the second result of an item.
// Depends on clt_pkg.
module clt_outbuf import clt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req,
    input  t_scan_res i_res,
    output logic      o_take,
    output logic      o_out_valid,
    output t_result   o_out_item,
    input  logic      i_out_stall
);

    logic    r_out_v, n_out_v;
    logic    r_pend_v, n_pend_v;
    t_result r_out, n_out;
    t_result r_pend, n_pend;
    logic    out_free;

    always_comb begin
        out_free = !r_out_v || !i_out_stall;
        // An item with no result needs no room; otherwise the result register must free up.
        o_take   = i_req && !r_pend_v && (i_res.count == 2'd0 || out_free);

        n_out_v  = r_out_v && i_out_stall;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        if (out_free) begin
            if (r_pend_v) begin
                n_out    = r_pend;
                n_out_v  = 1'b1;
                n_pend_v = 1'b0;
            end else if (o_take && i_res.count != 2'd0) begin
                n_out   = i_res.first;
                n_out_v = 1'b1;
                if (i_res.count == 2'd2) begin
                    n_pend   = i_res.second;
                    n_pend_v = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

[rtl/core/clt_checker.sv]
// Port-level checks of the command line tokenizer, bound to the top level.
// Depends on clt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clt_checker import clt_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_out_valid,
    input t_result o_out_item,
    input logic    i_out_stall
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item))

    // The end token is always the last of its run and carries no text.
    `ASSERT_SAME(a_end_shape, i_clk, i_rst_n, o_out_valid && o_out_item.token_type == TOK_END,
        o_out_item.last_of_run && o_out_item.text_length == '0 &&
        o_out_item.text_start == o_out_item.token_pos)

    `ASSERT_SAME(a_equals_shape, i_clk, i_rst_n,
        o_out_valid && o_out_item.token_type == TOK_EQUALS,
        o_out_item.text_length == POS_W'(1) && o_out_item.text_start == o_out_item.token_pos)

    // The second item of a pair follows right after the first is taken.
    `ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_item.last_of_run, o_out_valid)

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

[tb/command_line_tokenizer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for command_line_tokenizer: random command lines in,
// token descriptors checked against a scan predictor kept inside this file.
// Depends on clt_pkg and the command_line_tokenizer RTL.

module command_line_tokenizer_test;
    import clt_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    // The slowest correct run is about 1500 items at two descriptors each, with the
    // longest gaps and stalls on both sides; this allows several times that.
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    t_item   i_in_item;
    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_out_item;
    logic    i_out_stall;

    // Token descriptors still owed by the block, oldest first.
    t_result expected_tokens[$];

    // Scanner state as predicted from the accepted items.
    t_mode   sc_mode;
    int      sc_origin;
    int      sc_pos;
    bit      sc_alnum;
    bit      sc_ovf;
    t_result step_res[2];
    int      step_n;

    int errors;
    int items_sent;
    int tokens_seen;
    int cycles;
    bit tx_calm;
    bit rx_calm;
    bit hold_request;
    int hold_count;
    int rx_stall_left;

    command_line_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_scan();
        sc_mode   = MODE_IDLE;
        sc_origin = 0;
        sc_pos    = 0;
        sc_alnum  = 1'b1;
        sc_ovf    = 1'b0;
    endfunction

    function automatic bit word_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == CH_UNDERSCORE;
    endfunction

    function automatic bit breaks_word(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit skip_char(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic int span(int from, int upto);
        return (upto >= from) ? upto - from : 0;
    endfunction

    // Quoted text begins one past the opening quote, saturated like every offset.
    function automatic int quote_text();
        return (sc_origin + 1 > LINE_MAX) ? LINE_MAX : sc_origin + 1;
    endfunction

    function automatic void tok_emit(logic [2:0] kind, int pos, int start, int len);
        t_result r;
        if (step_n >= 2)
            return;
        r.token_type  = kind;
        r.token_pos   = POS_W'(pos);
        r.text_start  = POS_W'(start);
        r.text_length = POS_W'(len);
        r.last_of_run = 1'b0;
        r.overflow    = sc_ovf;
        step_res[step_n] = r;
        step_n++;
    endfunction

    function automatic void flush_token(int p);
        case (sc_mode)
            MODE_WORD:
                tok_emit(sc_alnum ? TOK_IDENT : TOK_VALUE, sc_origin, sc_origin,
                         span(sc_origin, p));
            MODE_DASH, MODE_SHORT:
                tok_emit(TOK_SHORT, sc_origin, sc_origin, span(sc_origin, p));
            MODE_LONG:
                tok_emit(TOK_LONG, sc_origin, sc_origin, span(sc_origin, p));
            MODE_QUOTE, MODE_QESC:
                tok_emit(TOK_UNTERM, sc_origin, quote_text(), span(quote_text(), p));
            default: ;
        endcase
        sc_mode = MODE_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] b, int p);
        if (skip_char(b))
            return;
        if (b == CH_EQUALS) begin
            tok_emit(TOK_EQUALS, p, p, 1);
            return;
        end
        sc_origin = p;
        if (b == CH_QUOTE)
            sc_mode = MODE_QUOTE;
        else if (b == CH_DASH)
            sc_mode = MODE_DASH;
        else begin
            sc_mode  = MODE_WORD;
            sc_alnum = word_char(b);
        end
    endfunction

    function automatic void quote_char(logic [7:0] b, int p);
        if (b == CH_QUOTE) begin
            tok_emit(TOK_QUOTED, sc_origin, quote_text(), span(quote_text(), p));
            sc_mode = MODE_IDLE;
        end else if (b == CH_BACKSLASH) begin
            sc_mode = MODE_QESC;
        end
    endfunction

    function automatic void predict_tokens(t_item it);
        int         p;
        logic [7:0] b;
        step_n = 0;
        b = it.byte_in;
        if (it.command == CMD_END) begin
            flush_token(sc_pos);
            tok_emit(TOK_END, sc_pos, sc_pos, 0);
            clear_scan();
        end else begin
            if (sc_pos >= LINE_MAX) begin
                sc_pos = LINE_MAX;
                sc_ovf = 1'b1;
            end
            p = sc_pos;
            if (sc_mode == MODE_DASH && b == CH_DASH) begin
                sc_mode = MODE_LONG;
            end else begin
                // A single dash becomes a short flag and its next byte is judged as one.
                if (sc_mode == MODE_DASH)
                    sc_mode = MODE_SHORT;
                case (sc_mode)
                    MODE_WORD: begin
                        if (breaks_word(b) || b == CH_EQUALS) begin
                            flush_token(p);
                            start_token(b, p);
                        end else if (!word_char(b)) begin
                            sc_alnum = 1'b0;
                        end
                    end
                    MODE_LONG, MODE_SHORT: begin
                        if (!word_char(b)) begin
                            flush_token(p);
                            start_token(b, p);
                        end
                    end
                    MODE_QUOTE:
                        quote_char(b, p);
                    MODE_QESC: begin
                        sc_mode = MODE_QUOTE;
                        if (b != CH_QUOTE)
                            quote_char(b, p);
                    end
                    default: begin
                        sc_mode = MODE_IDLE;
                        start_token(b, p);
                    end
                endcase
            end
            if (sc_pos < LINE_MAX)
                sc_pos++;
        end
        if (step_n > 0)
            step_res[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_tokens = {expected_tokens, step_res[i]};
    endfunction

    // ---------------------------------------------------------------- random helpers

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] word_letter();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 4))
            0: return ".";
            1: return CH_BACKSLASH;
            2: return 8'(8'h80 + $urandom_range(0, 127));
            3: return "/";
            default: return CH_DASH;
        endcase
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    // ---------------------------------------------------------------- sender

    task automatic send_item(t_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_tokens(it);
        items_sent++;
    endtask

    task automatic sender_gap();
        int n;
        if (tx_calm)
            return;
        n = pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item('{command: CMD_DATA, byte_in: b});
        sender_gap();
    endtask

    // The byte field of an end command is ignored, so it carries noise.
    task automatic send_end();
        send_item('{command: CMD_END, byte_in: 8'($urandom_range(0, 255))});
        sender_gap();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    task automatic send_random_token();
        int n;
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            2: repeat (n + 1) send_byte($urandom_range(0, 1) ? word_letter() : odd_char());
            3: begin
                send_byte(CH_DASH);
                repeat (n % 4) send_byte(word_letter());
            end
            4: begin
                send_text("--");
                repeat (n) send_byte(word_letter());
            end
            5: begin
                send_byte(CH_QUOTE);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0: send_byte(8'h20);
                        1: begin
                            send_byte(CH_BACKSLASH);
                            send_byte(CH_QUOTE);
                        end
                        2: send_byte(CH_BACKSLASH);
                        3: send_byte(CH_EQUALS);
                        default: send_byte(word_letter());
                    endcase
                end
                // Some quotes are left open so the rest of the line lands inside.
                if ($urandom_range(0, 4) != 0)
                    send_byte(CH_QUOTE);
            end
            6: send_byte(CH_EQUALS);
            7: send_byte(8'($urandom_range(0, 255)));
            default: repeat (n + 1) send_byte(word_letter());
        endcase
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_byte(random_blank());
            4: send_byte(CH_EQUALS);
            5: send_byte($urandom_range(0, 1) ? 8'h0B : 8'h0C);
            6: ;
            7: begin
                send_byte(random_blank());
                send_byte(random_blank());
            end
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_random_line();
        repeat ($urandom_range(1, 8)) begin
            send_random_token();
            send_separator();
        end
        send_end();
    endtask

    // ---------------------------------------------------------------- receiver

    function automatic void compare_field(string name, logic [POS_W-1:0] want,
                                          logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_token(t_result got);
        t_result want;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
            $error("token with no item waiting for it: type %0d at %0d",
                   got.token_type, got.token_pos);
            errors++;
            return;
        end
        want = expected_tokens.pop_front();
        compare_field("token_type", POS_W'(want.token_type), POS_W'(got.token_type));
        compare_field("token_pos", want.token_pos, got.token_pos);
        compare_field("text_start", want.text_start, got.text_start);
        compare_field("text_length", want.text_length, got.text_length);
        compare_field("last_of_run", POS_W'(want.last_of_run), POS_W'(got.last_of_run));
        compare_field("overflow", POS_W'(want.overflow), POS_W'(got.overflow));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_token(o_out_item);
        // A requested hold-off runs its full length regardless of other settings.
        if (hold_request) begin
            if (hold_count < HOLD_CYCLES) begin
                hold_count++;
                i_out_stall <= 1'b1;
            end else begin
                hold_request = 1'b0;
                hold_count   = 0;
                i_out_stall <= 1'b0;
            end
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else if (rx_calm) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_stall_left = pick_gap();
            i_out_stall <= (rx_stall_left != 0);
            if (rx_stall_left != 0)
                rx_stall_left--;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $error("no progress after %0d cycles, %0d tokens still owed",
                   cycles, expected_tokens.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        // Long flag closed by '=' gives two descriptors from one item.
        send_text("--ab=c");
        send_end();
        // Short flag ended by a vertical tab, which then opens a value word;
        // an escaped quote stays inside a quote left open at the end.
        send_text("-x");
        send_byte(8'h0B);
        send_text("9 \"a\\\"");
        send_end();
        // High byte as a value, empty quotes, a form feed word, and a line that
        // ends right after a backslash inside quotes.
        send_byte(8'hFF);
        send_text(" \"\"");
        send_byte(8'h0C);
        send_text(" \"\\");
        send_end();
        // Empty line.
        send_end();
        wait_drained();
    endtask

    task automatic test_random_lines(int count, bit calm);
        int stop;
        tx_calm = calm;
        rx_calm = calm;
        stop = items_sent + count;
        while (items_sent < stop)
            send_random_line();
        wait_drained();
    endtask

    // The receiver holds off while two-descriptor items keep coming, so the
    // block fills and has to stall its input.
    task automatic test_backpressure();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        hold_request = 1'b1;
        repeat (30) send_text("k=");
        send_end();
        wait_drained();
    endtask

    task automatic test_drain_pauses();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (6) begin
            send_random_line();
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        clear_scan();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_lines(950, 1'b0);
        test_backpressure();
        test_drain_pauses();
        test_random_lines(300, 1'b1);

        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d items and checked %0d token descriptors.", items_sent, tokens_seen);
        $display("Run included idle gaps, a long receiver hold-off and pauses until drained.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
